// ===== src/pdpb_pkg.sv =====
// ----------------------------------------------------------------------------
// pdpb_pkg
// Shared constants, register indexes and lane result type for the dual
// pulse peak and baseline analyzer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdpb_pkg;

  localparam int SAMPLE_BITS  = 14;
  localparam int TIME_BITS    = 16;
  localparam int SMOOTH_BITS  = 13;
  localparam int MAX_WINDOW   = 16;
  localparam int MAX_BASELINE = 1024;

  localparam int CFG_DATA_W   = 14;
  localparam int CFG_INDEX_W  = 2;
  localparam int WINDOW_REG_W = 5;
  localparam int BASE_REG_W   = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_INVERT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BASELINE = 2'd3;

  localparam logic                          RST_INVERT   = 1'b1;
  localparam logic signed [SAMPLE_BITS-1:0] RST_CUTOFF   = 14'sd90;
  localparam logic [WINDOW_REG_W-1:0]       RST_WINDOW   = 5'd7;
  localparam logic [BASE_REG_W-1:0]         RST_BASELINE = 11'd100;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] peak;
    logic [TIME_BITS-1:0]          peak_time;
    logic signed [SAMPLE_BITS-1:0] trough;
    logic [SMOOTH_BITS-1:0]        smooth;
    logic signed [SAMPLE_BITS-1:0] baseline;
  } lane_result_t;

endpackage

`default_nettype wire

// ===== src/pdpb_in_if.sv =====
// ----------------------------------------------------------------------------
// pdpb_in_if
// Sample pair channel: valid/ready handshake with timestamp, two channel
// samples and the end-of-waveform mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdpb_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [pdpb_pkg::TIME_BITS-1:0]          sample_time;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] sample_a;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] sample_b;
  logic                                    last_sample;

  modport source (output valid, sample_time, sample_a, sample_b, last_sample,
                  input ready);
  modport sink (input valid, sample_time, sample_a, sample_b, last_sample,
                output ready);
endinterface

`default_nettype wire

// ===== src/pdpb_out_if.sv =====
// ----------------------------------------------------------------------------
// pdpb_out_if
// Waveform result channel: valid/ready handshake with the per-channel
// peak, trough, smoothed peak and baseline figures and the accept flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdpb_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] peak_a;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] peak_b;
  logic [pdpb_pkg::TIME_BITS-1:0]          peak_time_a;
  logic [pdpb_pkg::TIME_BITS-1:0]          peak_time_b;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] trough_a;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] trough_b;
  logic [pdpb_pkg::SMOOTH_BITS-1:0]        smooth_peak_a;
  logic [pdpb_pkg::SMOOTH_BITS-1:0]        smooth_peak_b;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] baseline_a;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] baseline_b;
  logic                                    accepted;

  modport source (output valid, peak_a, peak_b, peak_time_a, peak_time_b,
                  trough_a, trough_b, smooth_peak_a, smooth_peak_b,
                  baseline_a, baseline_b, accepted,
                  input ready);
  modport sink (input valid, peak_a, peak_b, peak_time_a, peak_time_b,
                trough_a, trough_b, smooth_peak_a, smooth_peak_b,
                baseline_a, baseline_b, accepted,
                output ready);
endinterface

`default_nettype wire

// ===== src/pdpb_div.sv =====
// ----------------------------------------------------------------------------
// pdpb_div
// Unsigned restoring divider, one quotient bit per cycle. The quotient
// holds after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module pdpb_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic                  done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= CNT_W'(NUM_W);
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pdpb_lane.sv =====
// ----------------------------------------------------------------------------
// pdpb_lane
// One channel lane: optional sign inversion, running min and max with the
// max timestamp, zero-filled moving window sum and its best value, leading
// sample sum, and the end-of-waveform divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module pdpb_lane #(
  parameter int MAX_WINDOW   = pdpb_pkg::MAX_WINDOW,
  parameter int MAX_BASELINE = pdpb_pkg::MAX_BASELINE,
  localparam int SW     = pdpb_pkg::SAMPLE_BITS,
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1),
  localparam int CNT_W  = $clog2(MAX_BASELINE + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            take,
  input  wire logic                            last,
  input  wire logic                            invert,
  input  wire logic signed [SW-1:0]            sample,
  input  wire logic [pdpb_pkg::TIME_BITS-1:0]  stamp,
  input  wire logic [LEN_W-1:0]                live_width,
  input  wire logic                            in_base,
  input  wire logic [CNT_W-1:0]                count_next,
  output pdpb_pkg::lane_result_t               result
);

  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WSUM_W = SW + $clog2(MAX_WINDOW);
  localparam int BSUM_W = SW + $clog2(MAX_BASELINE);

  logic signed [SW-1:0]     taps [MAX_WINDOW];
  logic signed [SW-1:0]     run_min;
  logic signed [SW-1:0]     run_max;
  logic [pdpb_pkg::TIME_BITS-1:0] max_time;
  logic signed [WSUM_W-1:0] wsum;
  logic signed [WSUM_W-1:0] best;
  logic signed [BSUM_W-1:0] bsum;

  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] peak_r;
  logic signed [pdpb_pkg::SAMPLE_BITS-1:0] trough_r;
  logic [pdpb_pkg::TIME_BITS-1:0]          peak_time_r;
  logic                                    bneg;

  logic signed [SW-1:0]     s;
  logic [LEN_W-1:0]         lw_m1;
  logic [IDX_W-1:0]         lw_idx;
  logic signed [SW-1:0]     leaving;
  logic signed [SW-1:0]     min_next;
  logic signed [SW-1:0]     max_next;
  logic [pdpb_pkg::TIME_BITS-1:0] time_next;
  logic signed [WSUM_W-1:0] wsum_next;
  logic signed [WSUM_W-1:0] best_next;
  logic signed [BSUM_W-1:0] bsum_next;
  logic [BSUM_W-1:0]        bmag;
  logic                     start;

  logic [WSUM_W-1:0]        wq;
  logic [BSUM_W-1:0]        bq;
  logic [BSUM_W-1:0]        bq_signed;
  logic                     wdone;
  logic                     bdone;

  always_comb begin
    if (invert) begin
      s = (sample == pdpb_pkg::SAMPLE_MIN) ? pdpb_pkg::SAMPLE_MAX : -sample;
    end else begin
      s = sample;
    end
  end

  assign lw_m1   = live_width - 1'b1;
  assign lw_idx  = IDX_W'(lw_m1);
  assign leaving = taps[lw_idx];

  assign min_next  = (s < run_min) ? s : run_min;
  assign max_next  = (s > run_max) ? s : run_max;
  assign time_next = (s > run_max) ? stamp : max_time;
  assign wsum_next = wsum - WSUM_W'(leaving) + WSUM_W'(s);
  assign best_next = (wsum_next > best) ? wsum_next : best;
  assign bsum_next = in_base ? bsum + BSUM_W'(s) : bsum;
  assign bmag      = bsum_next[BSUM_W-1] ? BSUM_W'(~bsum_next + 1'b1) : BSUM_W'(bsum_next);
  assign start     = take && last;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      run_min  <= pdpb_pkg::SAMPLE_MAX;
      run_max  <= pdpb_pkg::SAMPLE_MIN;
      max_time <= '0;
      wsum     <= '0;
      best     <= '0;
      bsum     <= '0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
        taps[k] <= '0;
      end
    end else if (take) begin
      run_min  <= min_next;
      run_max  <= max_next;
      max_time <= time_next;
      wsum     <= wsum_next;
      best     <= best_next;
      bsum     <= bsum_next;
      taps[0]  <= s;
      for (int k = 1; k < MAX_WINDOW; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      peak_r      <= max_next;
      trough_r    <= min_next;
      peak_time_r <= time_next;
      bneg        <= bsum_next[BSUM_W-1];
    end
  end

  pdpb_div #(
    .NUM_W (WSUM_W),
    .DEN_W (LEN_W)
  ) u_wdiv (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (WSUM_W'(best_next)),
    .den   (live_width),
    .quo   (wq),
    .done  (wdone)
  );

  pdpb_div #(
    .NUM_W (BSUM_W),
    .DEN_W (CNT_W)
  ) u_bdiv (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (bmag),
    .den   (count_next),
    .quo   (bq),
    .done  (bdone)
  );

  assign bq_signed = bneg ? BSUM_W'(~bq + 1'b1) : bq;

  always_comb begin
    result.done      = wdone && bdone;
    result.peak      = peak_r;
    result.peak_time = peak_time_r;
    result.trough    = trough_r;
    result.smooth    = wq[pdpb_pkg::SMOOTH_BITS-1:0];
    result.baseline  = bq_signed[pdpb_pkg::SAMPLE_BITS-1:0];
  end

endmodule

`default_nettype wire

// ===== src/dual_pulse_peak_baseline_analyzer_core.sv =====
// ----------------------------------------------------------------------------
// dual_pulse_peak_baseline_analyzer_core
// Two-channel pulse analyzer: per-channel peak, peak time, trough, largest
// moving-window mean and leading-sample baseline, with an accept flag.
//
// Usage: sample pairs enter on the samples channel, one beat per clock while
// a waveform streams in. The beat with last_sample set closes the waveform;
// the two channel lanes then run their window and baseline divisions in
// parallel on restoring dividers, one quotient bit a cycle, and samples.ready
// is low meanwhile. The result sits in an output register: while it waits
// for results.ready the next waveform streams in, and only the loading of
// its own result waits for the register to free. Window width and baseline
// count are latched at the first beat of a waveform. Configuration is a
// plain write port (cfg_we, cfg_index, cfg_data). Synchronous reset restores
// the register defaults, clears all waveform state and drops results.valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_pulse_peak_baseline_analyzer_core #(
  parameter int MAX_WINDOW   = pdpb_pkg::MAX_WINDOW,
  parameter int MAX_BASELINE = pdpb_pkg::MAX_BASELINE
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  pdpb_in_if.sink                                 samples,
  pdpb_out_if.source                              results,
  input  wire logic                               cfg_we,
  input  wire logic [pdpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pdpb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(MAX_BASELINE + 1);
  localparam int SW    = pdpb_pkg::SAMPLE_BITS;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic                               invert;
  logic signed [SW-1:0]               cutoff;
  logic [pdpb_pkg::WINDOW_REG_W-1:0]  window_width;
  logic [pdpb_pkg::BASE_REG_W-1:0]    baseline_count;

  logic             wave_open;
  logic [LEN_W-1:0] live_width;
  logic [CNT_W-1:0] live_base;
  logic [CNT_W-1:0] count;

  logic [LEN_W-1:0] width_sat;
  logic [CNT_W-1:0] base_sat;
  logic [LEN_W-1:0] width_eff;
  logic [CNT_W-1:0] base_eff;
  logic             in_base;
  logic [CNT_W-1:0] count_next;
  logic             take;
  logic             lanes_done;
  logic             load;

  pdpb_pkg::lane_result_t res_a;
  pdpb_pkg::lane_result_t res_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert         <= pdpb_pkg::RST_INVERT;
      cutoff         <= pdpb_pkg::RST_CUTOFF;
      window_width   <= pdpb_pkg::RST_WINDOW;
      baseline_count <= pdpb_pkg::RST_BASELINE;
    end else if (cfg_we) begin
      case (cfg_index)
        pdpb_pkg::REG_INVERT:   invert         <= cfg_data[0];
        pdpb_pkg::REG_CUTOFF:   cutoff         <= $signed(cfg_data[SW-1:0]);
        pdpb_pkg::REG_WINDOW:   window_width   <= cfg_data[pdpb_pkg::WINDOW_REG_W-1:0];
        pdpb_pkg::REG_BASELINE: baseline_count <= cfg_data[pdpb_pkg::BASE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_width == '0) begin
      width_sat = LEN_W'(1);
    end else if (32'(window_width) > MAX_WINDOW) begin
      width_sat = LEN_W'(MAX_WINDOW);
    end else begin
      width_sat = LEN_W'(window_width);
    end
    if (baseline_count == '0) begin
      base_sat = CNT_W'(1);
    end else if (32'(baseline_count) > MAX_BASELINE) begin
      base_sat = CNT_W'(MAX_BASELINE);
    end else begin
      base_sat = CNT_W'(baseline_count);
    end
  end

  assign width_eff  = wave_open ? live_width : width_sat;
  assign base_eff   = wave_open ? live_base : base_sat;
  assign in_base    = count < base_eff;
  assign count_next = in_base ? count + 1'b1 : count;

  assign samples.ready = (state == ST_RUN);
  assign take          = samples.valid && samples.ready;
  assign lanes_done    = res_a.done && res_b.done;
  assign load          = (state == ST_DIV) && lanes_done && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_open  <= 1'b0;
      count      <= '0;
      live_width <= LEN_W'(1);
      live_base  <= CNT_W'(1);
    end else if (take) begin
      if (samples.last_sample) begin
        wave_open <= 1'b0;
        count     <= '0;
      end else begin
        wave_open  <= 1'b1;
        count      <= count_next;
        live_width <= width_eff;
        live_base  <= base_eff;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (take && samples.last_sample) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (load) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  pdpb_lane #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_BASELINE (MAX_BASELINE)
  ) u_lane_a (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .last       (samples.last_sample),
    .invert     (invert),
    .sample     (samples.sample_a),
    .stamp      (samples.sample_time),
    .live_width (width_eff),
    .in_base    (in_base),
    .count_next (count_next),
    .result     (res_a)
  );

  pdpb_lane #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_BASELINE (MAX_BASELINE)
  ) u_lane_b (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .last       (samples.last_sample),
    .invert     (invert),
    .sample     (samples.sample_b),
    .stamp      (samples.sample_time),
    .live_width (width_eff),
    .in_base    (in_base),
    .count_next (count_next),
    .result     (res_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.peak_a        <= res_a.peak;
      results.peak_b        <= res_b.peak;
      results.peak_time_a   <= res_a.peak_time;
      results.peak_time_b   <= res_b.peak_time;
      results.trough_a      <= res_a.trough;
      results.trough_b      <= res_b.trough;
      results.smooth_peak_a <= res_a.smooth;
      results.smooth_peak_b <= res_b.smooth;
      results.baseline_a    <= res_a.baseline;
      results.baseline_b    <= res_b.baseline;
      results.accepted      <= ($signed(res_a.peak) <= cutoff) &&
                               ($signed(res_b.peak) <= cutoff);
    end
  end

endmodule

`default_nettype wire

// ===== test/dual_pulse_peak_baseline_analyzer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pulse_peak_baseline_analyzer_core_tb
// Drives timestamped sample pairs into the analyzer, folds every accepted
// beat into a local waveform tracker, and compares each result beat field
// by field against the oldest pending waveform report. A short table of
// hand-picked beats and register writes comes first, then random waveforms
// over many register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module dual_pulse_peak_baseline_analyzer_core_tb;

  localparam int SB           = pdpb_pkg::SAMPLE_BITS;
  localparam int TB_W         = pdpb_pkg::TIME_BITS;
  localparam int MB_W         = pdpb_pkg::SMOOTH_BITS;
  localparam int IX_W         = pdpb_pkg::CFG_INDEX_W;
  localparam int DW           = pdpb_pkg::CFG_DATA_W;
  localparam int NWIN         = pdpb_pkg::MAX_WINDOW;
  localparam int NBASE        = pdpb_pkg::MAX_BASELINE;
  localparam int STUCK_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BEATS = 1150;

  typedef struct packed {
    logic signed [SB-1:0] peak_a;
    logic signed [SB-1:0] peak_b;
    logic [TB_W-1:0]      peak_time_a;
    logic [TB_W-1:0]      peak_time_b;
    logic signed [SB-1:0] trough_a;
    logic signed [SB-1:0] trough_b;
    logic [MB_W-1:0]      smooth_a;
    logic [MB_W-1:0]      smooth_b;
    logic signed [SB-1:0] base_a;
    logic signed [SB-1:0] base_b;
    logic                 acc;
  } wave_report_t;

  typedef struct packed {
    bit                   is_reg;
    logic [IX_W-1:0]      reg_idx;
    logic [DW-1:0]        reg_val;
    logic [TB_W-1:0]      stamp;
    logic signed [SB-1:0] a;
    logic signed [SB-1:0] b;
    bit                   last;
    bit                   typed;
    wave_report_t         want;
  } plan_row_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [IX_W-1:0] cfg_index;
  logic [DW-1:0]   cfg_data;

  pdpb_in_if  sin();
  pdpb_out_if sout();

  dual_pulse_peak_baseline_analyzer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (sin),
    .results   (sout),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register shadow
  bit                                     inv_cfg;
  logic signed [SB-1:0]                   cutoff_cfg;
  logic [pdpb_pkg::WINDOW_REG_W-1:0]      width_cfg;
  logic [pdpb_pkg::BASE_REG_W-1:0]        count_cfg;

  // waveform tracker
  logic signed [SB-1:0] lo_seen [2];
  logic signed [SB-1:0] hi_seen [2];
  logic [TB_W-1:0]      hi_time [2];
  logic signed [SB-1:0] taps [2][NWIN];
  int                   win_sum [2];
  int                   best_sum [2];
  int                   base_sum [2];
  int                   taken;
  int                   wpos;
  int                   wave_width;
  int                   wave_base;
  bit                   wave_open;

  wave_report_t reports_due[$];
  plan_row_t    plan[$];
  wave_report_t want_now;
  int           fault_count;
  int           stuck_cycles;
  int           random_beats;
  bit           sender_calm;
  bit           sink_calm;
  logic [TB_W-1:0] stamp;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_wave();
    int c;
    int k;
    for (c = 0; c < 2; c++) begin
      lo_seen[c]  = pdpb_pkg::SAMPLE_MAX;
      hi_seen[c]  = pdpb_pkg::SAMPLE_MIN;
      hi_time[c]  = '0;
      win_sum[c]  = 0;
      best_sum[c] = 0;
      base_sum[c] = 0;
      for (k = 0; k < NWIN; k++) taps[c][k] = '0;
    end
    taken     = 0;
    wpos      = 0;
    wave_open = 1'b0;
  endfunction

  function automatic bit fold_sample(input logic [TB_W-1:0] t,
                                     input logic signed [SB-1:0] a,
                                     input logic signed [SB-1:0] b,
                                     input bit last,
                                     output wave_report_t rep);
    logic signed [SB-1:0] s [2];
    int c;
    int old_pos;
    s[0] = a;
    s[1] = b;
    rep  = '0;
    if (inv_cfg) begin
      for (c = 0; c < 2; c++) begin
        s[c] = (s[c] == pdpb_pkg::SAMPLE_MIN) ? pdpb_pkg::SAMPLE_MAX : -s[c];
      end
    end
    if (!wave_open) begin
      wave_width = (width_cfg == 0) ? 1 : int'(width_cfg);
      if (wave_width > NWIN) wave_width = NWIN;
      wave_base = (count_cfg == 0) ? 1 : int'(count_cfg);
      if (wave_base > NBASE) wave_base = NBASE;
      wave_open = 1'b1;
    end
    for (c = 0; c < 2; c++) begin
      old_pos = (wpos + NWIN - wave_width) % NWIN;
      if (s[c] < lo_seen[c]) lo_seen[c] = s[c];
      if (s[c] > hi_seen[c]) begin
        hi_seen[c] = s[c];
        hi_time[c] = t;
      end
      win_sum[c] = win_sum[c] - taps[c][old_pos] + s[c];
      taps[c][wpos] = s[c];
      if (win_sum[c] > best_sum[c]) best_sum[c] = win_sum[c];
      if (taken < wave_base) base_sum[c] += s[c];
    end
    wpos = (wpos + 1) % NWIN;
    if (taken < wave_base) taken++;
    if (!last) return 1'b0;
    rep.peak_a      = hi_seen[0];
    rep.peak_b      = hi_seen[1];
    rep.peak_time_a = hi_time[0];
    rep.peak_time_b = hi_time[1];
    rep.trough_a    = lo_seen[0];
    rep.trough_b    = lo_seen[1];
    rep.smooth_a    = MB_W'(best_sum[0] / wave_width);
    rep.smooth_b    = MB_W'(best_sum[1] / wave_width);
    rep.base_a      = SB'(base_sum[0] / taken);
    rep.base_b      = SB'(base_sum[1] / taken);
    rep.acc         = (hi_seen[0] <= cutoff_cfg) && (hi_seen[1] <= cutoff_cfg);
    clear_wave();
    return 1'b1;
  endfunction

  function automatic wave_report_t make_report(int pa, int pb, int ta, int tb, int ra,
                                               int rb, int sa, int sb, int ba, int bb,
                                               bit acc);
    wave_report_t rep;
    rep.peak_a      = SB'(pa);
    rep.peak_b      = SB'(pb);
    rep.peak_time_a = TB_W'(ta);
    rep.peak_time_b = TB_W'(tb);
    rep.trough_a    = SB'(ra);
    rep.trough_b    = SB'(rb);
    rep.smooth_a    = MB_W'(sa);
    rep.smooth_b    = MB_W'(sb);
    rep.base_a      = SB'(ba);
    rep.base_b      = SB'(bb);
    rep.acc         = acc;
    return rep;
  endfunction

  function automatic void add_beat(int t, int a, int b, bit last);
    plan_row_t row;
    row       = '0;
    row.stamp = TB_W'(t);
    row.a     = SB'(a);
    row.b     = SB'(b);
    row.last  = last;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_checked(int t, int a, int b, wave_report_t want);
    plan_row_t row;
    row       = '0;
    row.stamp = TB_W'(t);
    row.a     = SB'(a);
    row.b     = SB'(b);
    row.last  = 1'b1;
    row.typed = 1'b1;
    row.want  = want;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_reg(logic [IX_W-1:0] idx, int val);
    plan_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = DW'(val);
    plan.insert(plan.size(), row);
  endfunction

  function automatic logic signed [SB-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return pdpb_pkg::SAMPLE_MIN;
      1:       return pdpb_pkg::SAMPLE_MAX;
      2, 3, 4: return SB'($urandom_range(0, 400) - 200);
      5:       return SB'($urandom_range(0, 4) - 2);
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [IX_W-1:0] idx,
                           input logic [DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      pdpb_pkg::REG_INVERT:   inv_cfg    = val[0];
      pdpb_pkg::REG_CUTOFF:   cutoff_cfg = val[SB-1:0];
      pdpb_pkg::REG_WINDOW:   width_cfg  = val[pdpb_pkg::WINDOW_REG_W-1:0];
      pdpb_pkg::REG_BASELINE: count_cfg  = val[pdpb_pkg::BASE_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle_block();
    sin.valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic drive_beat(input logic [TB_W-1:0] t,
                            input logic signed [SB-1:0] a,
                            input logic signed [SB-1:0] b,
                            input bit last, input bit typed, input wave_report_t want);
    int           gap;
    wave_report_t forecast;
    gap = sender_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      sin.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sin.valid       <= 1'b1;
    sin.sample_time <= t;
    sin.sample_a    <= a;
    sin.sample_b    <= b;
    sin.last_sample <= last;
    @(posedge clk);
    while (!sin.ready) @(posedge clk);
    if (fold_sample(t, a, b, last, forecast)) begin
      reports_due.insert(reports_due.size(), typed ? want : forecast);
    end
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles = 0;
    end else begin
      if ((sin.valid && sin.ready) || (sout.valid && sout.ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (sout.valid && sout.ready) begin
        if (reports_due.size() == 0) begin
          $error("result beat with no waveform pending");
          fault_count++;
        end else begin
          want_now = reports_due[0];
          reports_due.delete(0);
          check_field("peak_a", $signed(want_now.peak_a), $signed(sout.peak_a));
          check_field("peak_b", $signed(want_now.peak_b), $signed(sout.peak_b));
          check_field("peak_time_a", want_now.peak_time_a, sout.peak_time_a);
          check_field("peak_time_b", want_now.peak_time_b, sout.peak_time_b);
          check_field("trough_a", $signed(want_now.trough_a), $signed(sout.trough_a));
          check_field("trough_b", $signed(want_now.trough_b), $signed(sout.trough_b));
          check_field("smooth_peak_a", want_now.smooth_a, sout.smooth_peak_a);
          check_field("smooth_peak_b", want_now.smooth_b, sout.smooth_peak_b);
          check_field("baseline_a", $signed(want_now.base_a), $signed(sout.baseline_a));
          check_field("baseline_b", $signed(want_now.base_b), $signed(sout.baseline_b));
          check_field("accepted", want_now.acc, sout.accepted);
        end
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result sink: random backpressure with calm stretches
  initial begin
    int stall;
    sout.ready = 1'b0;
    sink_calm  = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        sout.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      sout.ready <= 1'b1;
      @(posedge clk);
      while (!sout.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int n_waves;
    int len;
    int w;
    int i;
    bit keep_open;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    sin.valid       = 1'b0;
    sin.sample_time = '0;
    sin.sample_a    = '0;
    sin.sample_b    = '0;
    sin.last_sample = 1'b0;
    fault_count     = 0;
    random_beats    = 0;
    sender_calm     = 1'b0;
    stamp           = '0;
    inv_cfg         = pdpb_pkg::RST_INVERT;
    cutoff_cfg      = pdpb_pkg::RST_CUTOFF;
    width_cfg       = pdpb_pkg::RST_WINDOW;
    count_cfg       = pdpb_pkg::RST_BASELINE;
    wave_width      = 1;
    wave_base       = 1;
    clear_wave();

    // defaults: invert on, cutoff 90, window 7, baseline 100
    add_checked(16'h1234, 100, -50,
                make_report(-100, 50, 16'h1234, 16'h1234, -100, 50, 0, 7, -100, 50, 1));
    // most negative input saturates when inverted
    add_checked(16'hFFFF, -8192, 8191,
                make_report(8191, -8191, 16'hFFFF, 16'hFFFF, 8191, -8191, 1170, 0,
                            8191, -8191, 0));
    add_reg(pdpb_pkg::REG_INVERT, 0);
    // flat at the most negative value: no new maximum, peak time stays zero
    add_beat(16'h0042, -8192, -8192, 1'b0);
    add_checked(16'h0043, -8192, -8192,
                make_report(-8192, -8192, 0, 0, -8192, -8192, 0, 0, -8192, -8192, 1));
    // zero width and zero count act as one
    add_reg(pdpb_pkg::REG_WINDOW, 0);
    add_reg(pdpb_pkg::REG_BASELINE, 0);
    add_reg(pdpb_pkg::REG_CUTOFF, -8192);
    add_beat(5, 8191, 0, 1'b0);
    add_checked(6, -1, 8191,
                make_report(8191, 8191, 5, 6, -1, 0, 8191, 8191, 8191, 0, 0));
    // oversize width and count saturate; waveform shorter than the baseline
    add_reg(pdpb_pkg::REG_WINDOW, 31);
    add_reg(pdpb_pkg::REG_BASELINE, 2047);
    add_reg(pdpb_pkg::REG_CUTOFF, 8191);
    for (i = 0; i < 8; i++) begin
      add_beat(i[0] ? 16'hAAAA : 16'h5555, i[0] ? 14'h2AAA : 14'h1555,
               i[0] ? 14'h1555 : 14'h2AAA, i == 7);
    end
    // register change with a waveform open
    add_beat(100, 300, -300, 1'b0);
    add_beat(101, -8192, 8191, 1'b0);
    add_beat(102, 7, -7, 1'b0);
    add_reg(pdpb_pkg::REG_INVERT, 1);
    add_reg(pdpb_pkg::REG_WINDOW, 3);
    add_reg(pdpb_pkg::REG_BASELINE, 2);
    add_beat(103, 4000, -4000, 1'b0);
    add_beat(104, -8192, 0, 1'b0);
    add_beat(105, 12, 8191, 1'b1);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_reg) begin
        if (k == 0 || !plan[k-1].is_reg) settle_block();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        drive_beat(plan[k].stamp, plan[k].a, plan[k].b, plan[k].last, plan[k].typed,
                   plan[k].want);
      end
    end

    while (random_beats < RANDOM_BEATS) begin
      settle_block();
      if ($urandom_range(0, 1)) begin
        write_reg(pdpb_pkg::REG_INVERT, DW'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       write_reg(pdpb_pkg::REG_CUTOFF, DW'(pdpb_pkg::SAMPLE_MIN));
          1:       write_reg(pdpb_pkg::REG_CUTOFF, DW'(pdpb_pkg::SAMPLE_MAX));
          2, 3:    write_reg(pdpb_pkg::REG_CUTOFF, DW'($urandom_range(0, 600) - 300));
          default: write_reg(pdpb_pkg::REG_CUTOFF, DW'($urandom));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0:       write_reg(pdpb_pkg::REG_WINDOW, DW'(0));
          1:       write_reg(pdpb_pkg::REG_WINDOW, DW'(31));
          2:       write_reg(pdpb_pkg::REG_WINDOW, DW'(NWIN));
          3:       write_reg(pdpb_pkg::REG_WINDOW, DW'(1));
          default: write_reg(pdpb_pkg::REG_WINDOW, DW'($urandom_range(0, 31)));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       write_reg(pdpb_pkg::REG_BASELINE, DW'(0));
          1:       write_reg(pdpb_pkg::REG_BASELINE, DW'(1));
          2:       write_reg(pdpb_pkg::REG_BASELINE, DW'(NBASE));
          3:       write_reg(pdpb_pkg::REG_BASELINE, DW'(2047));
          4:       write_reg(pdpb_pkg::REG_BASELINE, DW'($urandom_range(0, 2047)));
          default: write_reg(pdpb_pkg::REG_BASELINE, DW'($urandom_range(1, 40)));
        endcase
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      n_waves = $urandom_range(1, 8);
      for (w = 0; w < n_waves; w++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        keep_open = (w == n_waves - 1) && ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) stamp = TB_W'($urandom);
          else stamp = stamp + TB_W'($urandom_range(0, 3));
          drive_beat(stamp, draw_sample(), draw_sample(), (i == len - 1) && !keep_open,
                     1'b0, '0);
          random_beats++;
        end
      end
    end
    if (wave_open) drive_beat(stamp + 1'b1, draw_sample(), draw_sample(), 1'b1, 1'b0, '0);

    settle_block();
    if (reports_due.size() != 0) begin
      $error("%0d waveform reports never arrived", reports_due.size());
      fault_count++;
    end
    if (fault_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
